// ===== sv/rtcp_pkg.sv =====
// Package for the range-to-CIDR prefix block: command/status types and
// bit-scan helpers shared by the controller, datapath and top level.
// No dependencies.
package rtcp_pkg;

   localparam int unsigned AddrBits = 32;
   localparam int unsigned LenBits  = 6;

   typedef struct packed {
      logic load;   // capture and order a new address pair
      logic step;   // emit one prefix and advance
   } rtcp_cmd_type;

   typedef struct packed {
      logic last;   // prefix being emitted this cycle closes the range
   } rtcp_status_type;

   // trailing zero count of a 32-bit address, 32 for zero
   function automatic logic [LenBits-1:0] trailing_zeros(input logic [AddrBits-1:0] value);
      logic [LenBits-1:0] count;
      count = LenBits'(AddrBits);
      for (int i = AddrBits - 1; i >= 0; i--) begin
         if (value[i]) count = LenBits'(i);
      end
      return count;
   endfunction

   // index of the highest set bit of a 33-bit span, 0 for zero
   function automatic logic [LenBits-1:0] highest_one(input logic [AddrBits:0] value);
      logic [LenBits-1:0] index;
      index = '0;
      for (int i = 0; i <= AddrBits; i++) begin
         if (value[i]) index = LenBits'(i);
      end
      return index;
   endfunction

endpackage

// ===== sv/rtcp_ctrl.sv =====
// Controller for the range-to-CIDR prefix block: two-state sequencer that
// loads an address pair and steps the datapath until the last prefix.
// Depends on rtcp_pkg.
module rtcp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output rtcp_pkg::rtcp_cmd_type    cmd,
   input  rtcp_pkg::rtcp_status_type status
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (status.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == ST_RUN);

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not start a run");

   a_keeps_running: assert property (@(posedge clock) disable iff (reset)
      busy && !status.last |=> busy)
      else $error("run ended before the last prefix");

   a_stops_after_last: assert property (@(posedge clock) disable iff (reset)
      busy && status.last |=> !busy)
      else $error("run continued past the last prefix");

endmodule

// ===== sv/rtcp_dp.sv =====
// Datapath for the range-to-CIDR prefix block: holds the current start and
// remaining span, finds one prefix per step and registers the result ports.
// Depends on rtcp_pkg.
module rtcp_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rtcp_pkg::rtcp_cmd_type                 cmd,
   output rtcp_pkg::rtcp_status_type              status,
   input  logic [rtcp_pkg::AddrBits-1:0]          req_first_address,
   input  logic [rtcp_pkg::AddrBits-1:0]          req_second_address,
   output logic                                  rsp_valid,
   output logic [rtcp_pkg::AddrBits-1:0]          rsp_prefix_network,
   output logic [rtcp_pkg::LenBits-1:0]           rsp_prefix_length,
   output logic                                  rsp_last_prefix
);

   localparam int unsigned AW = rtcp_pkg::AddrBits;
   localparam int unsigned LW = rtcp_pkg::LenBits;

   logic [AW-1:0] lo_ff,  lo_in;
   logic [AW:0]   rem_ff, rem_in;     // addresses left in the range, up to 2^32
   logic          valid_ff, valid_in;
   logic [AW-1:0] network_ff;
   logic [LW-1:0] length_ff;
   logic          last_ff;

   logic [AW:0]   diff;
   logic [LW-1:0] tz;
   logic [LW-1:0] hb;
   logic [LW-1:0] k;
   logic [AW:0]   size;

   // block size: limited by alignment of the start and by the span left
   always_comb begin
      tz   = rtcp_pkg::trailing_zeros(lo_ff);
      hb   = rtcp_pkg::highest_one(rem_ff);
      k    = (tz < hb) ? tz : hb;
      size = (AW + 1)'(1) << k;
      status.last = (rem_ff == size);
   end

   always_comb begin
      diff   = {1'b0, req_second_address} - {1'b0, req_first_address};
      lo_in  = lo_ff;
      rem_in = rem_ff;
      if (cmd.load) begin
         // borrow means the second address is the lower one
         if (diff[AW]) begin
            lo_in  = req_second_address;
            rem_in = {1'b0, req_first_address} - {1'b0, req_second_address}
                     + (AW + 1)'(1);
         end else begin
            lo_in  = req_first_address;
            rem_in = diff + (AW + 1)'(1);
         end
      end else if (cmd.step) begin
         lo_in  = lo_ff + size[AW-1:0];
         rem_in = rem_ff - size;
      end
      valid_in = cmd.step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      rem_ff <= rem_in;
      if (cmd.step) begin
         network_ff <= lo_ff;
         length_ff  <= LW'(AW) - k;
         last_ff    <= status.last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_prefix_network = network_ff;
   assign rsp_prefix_length  = length_ff;
   assign rsp_last_prefix    = last_ff;

   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> rem_ff != '0)
      else $error("step with an empty span");

   a_block_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> size <= rem_ff)
      else $error("prefix runs past the range end");

   a_block_aligned: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> ({1'b0, lo_ff} & (size - (AW + 1)'(1))) == '0)
      else $error("prefix not aligned to its start");

endmodule

// ===== sv/range_to_cidr_prefixes_top.sv =====
// Range-to-CIDR prefix block: one start transfer gives 1 to 62 prefixes, one per
// cycle; the first is registered on the result ports at the first step after the load.
// Busy stays high until the last prefix is out, and a new start is taken only once
// busy drops; the rate is set by the one-prefix-per-step bit-scan loop.
// Receiver cannot stall. Synchronous reset clears sequencer and result strobe.
// Depends on rtcp_pkg, rtcp_ctrl and rtcp_dp.
module range_to_cidr_prefixes_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rtcp_pkg::AddrBits-1:0]      req_first_address,
   input  logic [rtcp_pkg::AddrBits-1:0]      req_second_address,
   output logic                              rsp_valid,
   output logic [rtcp_pkg::AddrBits-1:0]      rsp_prefix_network,
   output logic [rtcp_pkg::LenBits-1:0]       rsp_prefix_length,
   output logic                              rsp_last_prefix
);

   rtcp_pkg::rtcp_cmd_type    cmd;
   rtcp_pkg::rtcp_status_type status;

   rtcp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   rtcp_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_first_address  (req_first_address),
      .req_second_address (req_second_address),
      .rsp_valid          (rsp_valid),
      .rsp_prefix_network (rsp_prefix_network),
      .rsp_prefix_length  (rsp_prefix_length),
      .rsp_last_prefix    (rsp_last_prefix)
   );

endmodule

// ===== dv/tb.sv =====
// Testbench for range_to_cidr_prefixes_top: drives address pairs, predicts the
// CIDR prefix list of each inclusive range and checks every result transfer.
// Depends on rtcp_pkg and the RTL of range_to_cidr_prefixes_top.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned StallLimit = 2000;
   localparam int unsigned NumRandom  = 240;
   localparam int unsigned QuietTail  = 40;

   typedef struct packed {
      logic [rtcp_pkg::AddrBits-1:0] network;
      logic [rtcp_pkg::LenBits-1:0]  length;
      logic                          closes;
   } cidr_type;

   typedef struct packed {
      logic [rtcp_pkg::AddrBits-1:0] addr_a;
      logic [rtcp_pkg::AddrBits-1:0] addr_b;
      logic                          wait_drain;
   } range_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [rtcp_pkg::AddrBits-1:0] req_first_address  = '0;
   logic [rtcp_pkg::AddrBits-1:0] req_second_address = '0;
   logic                          rsp_valid;
   logic [rtcp_pkg::AddrBits-1:0] rsp_prefix_network;
   logic [rtcp_pkg::LenBits-1:0]  rsp_prefix_length;
   logic                          rsp_last_prefix;

   range_type   range_q[$];
   cidr_type    cidr_due_q[$];
   range_type   cur_range;
   range_type   took_range;
   logic        took_valid   = 1'b0;
   logic        cidr_q_empty = 1'b1;
   int unsigned idle_gap     = 0;
   int unsigned idle_pct     = 0;
   int unsigned taken_cnt    = 0;
   int unsigned stall_cnt    = 0;
   int unsigned error_cnt    = 0;

   range_to_cidr_prefixes_top u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_first_address  (req_first_address),
      .req_second_address (req_second_address),
      .rsp_valid          (rsp_valid),
      .rsp_prefix_network (rsp_prefix_network),
      .rsp_prefix_length  (rsp_prefix_length),
      .rsp_last_prefix    (rsp_last_prefix)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // minimal prefix cover of the inclusive range, ascending
   function automatic void cover_range(input logic [rtcp_pkg::AddrBits-1:0] a,
                                       input logic [rtcp_pkg::AddrBits-1:0] b);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] nxt;
      int unsigned k;
      int unsigned n;
      logic        done;
      cidr_type    p;
      lo   = (a < b) ? 64'(a) : 64'(b);
      hi   = (a < b) ? 64'(b) : 64'(a);
      n    = 0;
      done = 1'b0;
      while (!done) begin
         k = 0;
         while (k < rtcp_pkg::AddrBits && (lo & ((64'd1 << (k + 1)) - 1)) == 0 &&
                lo + (64'd1 << (k + 1)) - 1 <= hi)
            k++;
         nxt       = lo + (64'd1 << k);
         p.network = lo[rtcp_pkg::AddrBits-1:0];
         p.length  = rtcp_pkg::LenBits'(rtcp_pkg::AddrBits - k);
         p.closes  = (nxt > hi);
         cidr_due_q = {cidr_due_q, p};
         n++;
         done = p.closes || n >= 62;
         lo   = nxt;
      end
   endfunction

   task automatic add_range(input logic [rtcp_pkg::AddrBits-1:0] a,
                            input logic [rtcp_pkg::AddrBits-1:0] b,
                            input logic drain);
      range_type r;
      r.addr_a     = a;
      r.addr_b     = b;
      r.wait_drain = drain;
      range_q = {range_q, r};
   endtask

   // driver: start held until busy drops, bursts of idle between transfers
   always @(posedge clock) begin
      logic fire;
      logic drained;
      logic next_start;
      fire       = start && !busy;
      drained    = !fire && !took_valid && cidr_q_empty;
      next_start = start && !fire;
      if (reset) begin
         start      <= 1'b0;
         took_valid <= 1'b0;
      end else begin
         took_valid <= fire;
         if (fire) begin
            took_range <= cur_range;
            taken_cnt++;
            if (taken_cnt % 50 == 0)
               idle_pct = $urandom_range(0, 3) * 25;
            if (range_q.size() > QuietTail && $urandom_range(1, 100) <= idle_pct)
               idle_gap = $urandom_range(1, 8);
         end
         if (!next_start) begin
            if (idle_gap > 0) begin
               idle_gap--;
            end else if (range_q.size() > 0 && (!range_q[0].wait_drain || drained)) begin
               cur_range = range_q.pop_front();
               req_first_address  <= cur_range.addr_a;
               req_second_address <= cur_range.addr_b;
               next_start = 1'b1;
            end
         end
         start <= next_start;
      end
   end

   // monitor: expectations are queued in the cycle after the start transfer
   always @(posedge clock) begin
      cidr_type want;
      if (!reset) begin
         if (took_valid)
            cover_range(took_range.addr_a, took_range.addr_b);
         if (rsp_valid) begin
            if (cidr_due_q.size() == 0) begin
               $display("%0t: unexpected prefix %h/%0d last %0b", $time,
                        rsp_prefix_network, rsp_prefix_length, rsp_last_prefix);
               error_cnt++;
            end else begin
               want = cidr_due_q.pop_front();
               if (rsp_prefix_network !== want.network) begin
                  $display("%0t: prefix_network expected %h actual %h", $time,
                           want.network, rsp_prefix_network);
                  error_cnt++;
               end
               if (rsp_prefix_length !== want.length) begin
                  $display("%0t: prefix_length expected %0d actual %0d", $time,
                           want.length, rsp_prefix_length);
                  error_cnt++;
               end
               if (rsp_last_prefix !== want.closes) begin
                  $display("%0t: last_prefix expected %0b actual %0b", $time,
                           want.closes, rsp_last_prefix);
                  error_cnt++;
               end
            end
         end
         cidr_q_empty <= (cidr_due_q.size() == 0);
         if (rsp_valid || (start && !busy))
            stall_cnt <= 0;
         else
            stall_cnt <= stall_cnt + 1;
      end
   end

   initial begin
      wait (stall_cnt >= StallLimit);
      $display("range_to_cidr_prefixes_top verification failed");
      $finish;
   end

   initial begin
      logic [rtcp_pkg::AddrBits-1:0] a;
      logic [rtcp_pkg::AddrBits-1:0] b;
      logic [63:0]                   wide;
      int unsigned                   len;

      // directed: extremes, order, full space, longest cover
      add_range(32'h0000_0000, 32'h0000_0000, 1'b0);
      add_range(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_range(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      add_range(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      add_range(32'h0000_0001, 32'hFFFF_FFFE, 1'b0);
      add_range(32'hFFFF_FFFE, 32'h0000_0001, 1'b0);
      add_range(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
      add_range(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      add_range(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
      add_range(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
      add_range(32'hC0A8_0100, 32'hC0A8_01FF, 1'b0);
      add_range(32'hC0A8_0101, 32'hC0A8_01FE, 1'b0);
      add_range(32'h0A00_0005, 32'h0A00_0005, 1'b0);
      add_range(32'h0000_0000, 32'h0000_0001, 1'b0);
      add_range(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
      add_range(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      add_range(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
      add_range(32'h0000_0000, 32'hFFFF_FFFE, 1'b0);
      add_range(32'h1234_5678, 32'h1234_5677, 1'b0);
      add_range(32'hFFFF_0000, 32'h0000_FFFF, 1'b0);

      for (int i = 0; i < NumRandom; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               a = $urandom;
               b = $urandom;
            end
            4, 5: begin
               a    = $urandom;
               wide = 64'(a) + $urandom_range(0, 300);
               b    = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[rtcp_pkg::AddrBits-1:0];
            end
            6: begin
               // one aligned block, edges nudged now and then
               len  = $urandom_range(0, 32);
               wide = (len == 0) ? 64'd0 : (64'($urandom) >> (32 - len)) << (32 - len);
               a    = wide[rtcp_pkg::AddrBits-1:0];
               wide = wide + (64'd1 << (32 - len)) - 1;
               b    = wide[rtcp_pkg::AddrBits-1:0];
               if ($urandom_range(0, 2) == 0 && a != 32'hFFFF_FFFF) a = a + 1;
               if ($urandom_range(0, 2) == 0 && b != 32'h0000_0000) b = b - 1;
            end
            7: begin
               a = $urandom;
               b = a;
            end
            8: begin
               a    = $urandom;
               wide = 64'(a) + (64'd1 << $urandom_range(0, 31)) + $urandom_range(0, 3);
               b    = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[rtcp_pkg::AddrBits-1:0];
            end
            default: begin
               a = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
               b = $urandom;
            end
         endcase
         if ($urandom_range(0, 1))
            add_range(b, a, (i == 0 || i == NumRandom / 2));
         else
            add_range(a, b, (i == 0 || i == NumRandom / 2));
      end

      wait (!reset);
      @(posedge clock);
      while (!(range_q.size() == 0 && !start && !took_valid && cidr_q_empty))
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_cnt == 0 && cidr_due_q.size() == 0 && !took_valid)
         $display("range_to_cidr_prefixes_top verification clean");
      else
         $display("range_to_cidr_prefixes_top verification failed");
      $finish;
   end

endmodule

// ===== range_to_cidr_prefixes_top.f =====
sv/rtcp_pkg.sv
sv/rtcp_ctrl.sv
sv/rtcp_dp.sv
sv/range_to_cidr_prefixes_top.sv
dv/tb.sv
